>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks that can be compiled out with ASSERT_OFF
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property holds at every edge outside reset
`define PDM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// consequent holds in the cycle after the antecedent
`define PDM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PDM_ASSERT(lbl, clk, rst, prop, msg)
`define PDM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/core/pdm_pkg.sv
// ---------------------------------------------------------------------------
// pdm_pkg
// widths, codes, constants and stage types of the planar distance block
// ---------------------------------------------------------------------------
`default_nettype none

package pdm_pkg;

  localparam int CoordW   = 16;
  localparam int DiffW    = 17;
  localparam int ProdW    = 34;
  localparam int CrossW   = 35;
  localparam int MagW     = 34;
  localparam int HalfW    = 17;
  localparam int DenW     = 34;
  localparam int NumW     = 84;
  localparam int RootW    = 90;
  localparam int TW       = 62;
  localparam int DistW    = 25;
  localparam int OutW     = 26;
  localparam int ProjW    = 56;
  localparam int AngW     = 17;
  localparam int RedW     = 16;
  localparam int FoldW    = 13;
  localparam int XW       = 30;
  localparam int QW       = 31;
  localparam int UW       = 25;
  localparam int UpW      = 51;
  localparam int GapW     = 25;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 25;

  // angle units: hundredths of a degree
  localparam int Turn    = 36000;
  localparam int Half    = 18000;
  localparam int Quarter = 9000;
  localparam int Eighth  = 4500;

  // pi in q30 split as quotient and remainder of a division by 18000
  localparam logic [17:0] PiQuot   = 18'd187403;
  localparam logic [12:0] PiRem    = 13'd5426;
  localparam logic [13:0] RadBias  = 14'd9000;
  localparam logic [25:0] Recip18k = 26'd61083980;
  localparam int          Recip18kShift = 40;

  localparam logic [QW-1:0] Q30One  = QW'(32'h4000_0000);
  localparam logic [29:0]   Q30Half = 30'h2000_0000;

  localparam int HornerSteps = 5;
  localparam int HornerKCos [HornerSteps] = '{90, 56, 30, 12, 2};
  localparam int HornerKSin [HornerSteps] = '{110, 72, 42, 20, 6};

  typedef enum logic [1:0] {
    CMD_POINT = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_PAIR  = 2'd2,
    CMD_BAD   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_GAP   = 2'd1,
    ST_DEGEN = 2'd2,
    ST_MODE  = 2'd3
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PT_EN  = 3'd0,
    REG_PT_ANG = 3'd1,
    REG_LN_EN  = 3'd2,
    REG_LN_ANG = 3'd3,
    REG_GAP    = 3'd4
  } reg_idx_t;

  // rounding root recurrence: r = num - m*m*den, t = m*den, m = 2n-1
  typedef struct packed {
    logic signed [RootW-1:0] r;
    logic signed [TW-1:0]    t;
    logic [DistW-1:0]        n;
    logic [DenW-1:0]         den;
  } root_t;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [XW-1:0] x2;
    logic [QW-1:0] t;
    logic          use_sin;
    logic          neg;
  } cos_t;

endpackage

`default_nettype wire

>>> rtl/core/pdm_in_if.sv
// ---------------------------------------------------------------------------
// pdm_in_if
// measurement request channel: mode and four points
// ---------------------------------------------------------------------------
`default_nettype none

interface pdm_in_if
  import pdm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic signed [CoordW-1:0] p0_x;
  logic signed [CoordW-1:0] p0_y;
  logic signed [CoordW-1:0] p1_x;
  logic signed [CoordW-1:0] p1_y;
  logic signed [CoordW-1:0] p2_x;
  logic signed [CoordW-1:0] p2_y;
  logic signed [CoordW-1:0] p3_x;
  logic signed [CoordW-1:0] p3_y;

  modport source (output valid, cmd, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                  input ready);
  modport sink   (input valid, cmd, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/pdm_out_if.sv
// ---------------------------------------------------------------------------
// pdm_out_if
// measurement result channel: distance and status
// ---------------------------------------------------------------------------
`default_nettype none

interface pdm_out_if
  import pdm_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] distance;
  logic [1:0]             status;

  modport source (output valid, distance, status, input ready);
  modport sink   (input valid, distance, status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/planar_distance_measure.sv
// ---------------------------------------------------------------------------
// planar_distance_measure
// point-point, point-line and line-line distances in q8 fixed point
// ---------------------------------------------------------------------------
// One measurement per clock. A request accepted at a clock edge passes
// through five front stages (differences, products, cross product and
// lengths, partial squares, root set-up), 25 root stages that settle one
// result bit each, a projection stage and the output register. When the
// result is not taken the whole pipe holds, and ready drops only while the
// output register is full and stalled. The two cosine units run freely from
// the angle registers and settle after an angle write, well before an item
// accepted after it needs them.
`default_nettype none

`include "assert_macros.svh"

module planar_distance_measure
  import pdm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  pdm_in_if.sink              req,
  pdm_out_if.source           rsp
);

  // configuration
  logic                   pt_en, ln_en;
  logic signed [AngW-1:0] pt_ang, ln_ang;
  logic [GapW-1:0]        gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_en  <= 1'b0;
      pt_ang <= '0;
      ln_en  <= 1'b0;
      ln_ang <= '0;
      gap    <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PT_EN:  pt_en  <= cfg_data[0];
        REG_PT_ANG: pt_ang <= signed'(cfg_data[AngW-1:0]);
        REG_LN_EN:  ln_en  <= cfg_data[0];
        REG_LN_ANG: ln_ang <= signed'(cfg_data[AngW-1:0]);
        REG_GAP:    gap    <= cfg_data[GapW-1:0];
        default: ;
      endcase
    end
  end

  logic [QW-1:0] pt_cos, ln_cos;
  logic          pt_neg, ln_neg;

  pdm_cosine u_pt_cos (.clk(clk), .angle(pt_ang), .mag(pt_cos), .neg(pt_neg));
  pdm_cosine u_ln_cos (.clk(clk), .angle(ln_ang), .mag(ln_cos), .neg(ln_neg));

  logic adv;
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  // stage 1: differences
  logic                    v1;
  cmd_t                    cmd1;
  logic signed [DiffW-1:0] dx1, dy1, ux1, uy1, wx0_1, wy0_1, wx1_1, wy1_1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= req.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1  <= cmd_t'(req.cmd);
      dx1   <= DiffW'(req.p0_x) - DiffW'(req.p1_x);
      dy1   <= DiffW'(req.p0_y) - DiffW'(req.p1_y);
      ux1   <= DiffW'(req.p3_x) - DiffW'(req.p2_x);
      uy1   <= DiffW'(req.p3_y) - DiffW'(req.p2_y);
      wx0_1 <= DiffW'(req.p0_x) - DiffW'(req.p2_x);
      wy0_1 <= DiffW'(req.p0_y) - DiffW'(req.p2_y);
      wx1_1 <= DiffW'(req.p1_x) - DiffW'(req.p2_x);
      wy1_1 <= DiffW'(req.p1_y) - DiffW'(req.p2_y);
    end
  end

  // stage 2: products
  logic                    v2, deg2;
  cmd_t                    cmd2;
  logic signed [ProdW-1:0] pa1, pa2, pb1, pb2, uu2, vv2, ddx2, ddy2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd2 <= cmd1;
      deg2 <= (ux1 == '0) && (uy1 == '0);
      pa1  <= ProdW'(ux1) * ProdW'(wy0_1);
      pa2  <= ProdW'(uy1) * ProdW'(wx0_1);
      pb1  <= ProdW'(ux1) * ProdW'(wy1_1);
      pb2  <= ProdW'(uy1) * ProdW'(wx1_1);
      uu2  <= ProdW'(ux1) * ProdW'(ux1);
      vv2  <= ProdW'(uy1) * ProdW'(uy1);
      ddx2 <= ProdW'(dx1) * ProdW'(dx1);
      ddy2 <= ProdW'(dy1) * ProdW'(dy1);
    end
  end

  // stage 3: cross products, squared lengths
  logic signed [CrossW-1:0] cra, crb;
  logic                     v3, deg3;
  cmd_t                     cmd3;
  logic [MagW-1:0]          absa3, absb3;
  logic [DenW-1:0]          len3, s3;

  always_comb begin
    cra = CrossW'(pa1) - CrossW'(pa2);
    crb = CrossW'(pb1) - CrossW'(pb2);
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd3  <= cmd2;
      deg3  <= deg2;
      absa3 <= cra[CrossW-1] ? MagW'(-cra) : MagW'(cra);
      absb3 <= crb[CrossW-1] ? MagW'(-crb) : MagW'(crb);
      len3  <= DenW'($unsigned(uu2)) + DenW'($unsigned(vv2));
      s3    <= DenW'($unsigned(ddx2)) + DenW'($unsigned(ddy2));
    end
  end

  // stage 4: partial squares of the cross magnitudes
  logic            v4, deg4;
  cmd_t            cmd4;
  logic [DenW-1:0] len4, s4;
  logic [ProdW-1:0] ahh, ahl, all, bhh, bhl, bll;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd4 <= cmd3;
      deg4 <= deg3;
      len4 <= len3;
      s4   <= s3;
      ahh  <= ProdW'(absa3[MagW-1:HalfW]) * ProdW'(absa3[MagW-1:HalfW]);
      ahl  <= ProdW'(absa3[MagW-1:HalfW]) * ProdW'(absa3[HalfW-1:0]);
      all  <= ProdW'(absa3[HalfW-1:0]) * ProdW'(absa3[HalfW-1:0]);
      bhh  <= ProdW'(absb3[MagW-1:HalfW]) * ProdW'(absb3[MagW-1:HalfW]);
      bhl  <= ProdW'(absb3[MagW-1:HalfW]) * ProdW'(absb3[HalfW-1:0]);
      bll  <= ProdW'(absb3[HalfW-1:0]) * ProdW'(absb3[HalfW-1:0]);
    end
  end

  // stage 5: root set-up, (cross << 9)^2 over the squared length, or squared distance << 18 for points
  logic [NumW-1:0] sqa, sqb, numa;
  logic [DenW-1:0] dena;
  root_t           ra [DistW+1];
  root_t           rb [DistW+1];
  logic [DistW:0]  sb_v;
  logic [DistW:0]  sb_deg;
  cmd_t            sb_cmd [DistW+1];

  always_comb begin
    sqa  = (NumW'(ahh) << 52) + (NumW'(ahl) << 36) + (NumW'(all) << 18);
    sqb  = (NumW'(bhh) << 52) + (NumW'(bhl) << 36) + (NumW'(bll) << 18);
    numa = (cmd4 == CMD_POINT) ? NumW'(s4) << 18 : sqa;
    dena = (cmd4 == CMD_POINT) ? DenW'(1) : len4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ra[0].r   <= signed'(RootW'(numa)) - signed'(RootW'(dena));
      ra[0].t   <= -signed'(TW'(dena));
      ra[0].n   <= '0;
      ra[0].den <= dena;
      rb[0].r   <= signed'(RootW'(sqb)) - signed'(RootW'(len4));
      rb[0].t   <= -signed'(TW'(len4));
      rb[0].n   <= '0;
      rb[0].den <= len4;
    end
  end

  for (genvar g = 0; g < DistW; g++) begin : g_root
    pdm_root_step #(.Bit(DistW - 1 - g)) u_ra (
      .clk (clk), .adv (adv), .din (ra[g]), .dout (ra[g+1])
    );
    pdm_root_step #(.Bit(DistW - 1 - g)) u_rb (
      .clk (clk), .adv (adv), .din (rb[g]), .dout (rb[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) sb_v <= '0;
    else if (adv) sb_v <= {sb_v[DistW-1:0], v4};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_deg    <= {sb_deg[DistW-1:0], deg4};
      sb_cmd[0] <= cmd4;
      for (int i = 0; i < DistW; i++) begin
        sb_cmd[i+1] <= sb_cmd[i];
      end
    end
  end

  // projection stage
  logic [DistW-1:0] ha, hb;
  logic             v6, deg6, neg6, en6;
  cmd_t             cmd6;
  logic [DistW-1:0] ha6, diff6;
  logic [OutW-1:0]  sum6;
  logic [ProjW-1:0] prod6;

  assign ha = ra[DistW].n;
  assign hb = rb[DistW].n;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (adv) v6 <= sb_v[DistW];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd6  <= sb_cmd[DistW];
      deg6  <= sb_deg[DistW];
      ha6   <= ha;
      sum6  <= OutW'(ha) + OutW'(hb);
      diff6 <= (ha > hb) ? ha - hb : hb - ha;
      if (sb_cmd[DistW] == CMD_POINT) begin
        prod6 <= ProjW'(ha) * ProjW'(pt_cos);
        neg6  <= pt_neg;
        en6   <= pt_en;
      end else begin
        prod6 <= ProjW'(ha) * ProjW'(ln_cos);
        neg6  <= ln_neg;
        en6   <= ln_en;
      end
    end
  end

  // result select
  logic [ProjW-1:0]       prnd;
  logic [OutW-1:0]        pmag;
  logic signed [OutW-1:0] proj, plain, dist_next;
  logic [OutW-1:0]        avg;
  status_t                st_next;

  always_comb begin
    prnd      = prod6 + ProjW'(Q30Half);
    pmag      = prnd[ProjW-1:30];
    proj      = neg6 ? -signed'(pmag) : signed'(pmag);
    plain     = en6 ? proj : signed'(OutW'(ha6));
    avg       = (sum6 + OutW'(1)) >> 1;
    dist_next = '0;
    st_next   = ST_OK;
    case (cmd6)
      CMD_POINT: dist_next = plain;
      CMD_LINE: begin
        if (deg6) st_next = ST_DEGEN;
        else dist_next = plain;
      end
      CMD_PAIR: begin
        if (deg6) st_next = ST_DEGEN;
        else if (diff6 < gap) dist_next = signed'(avg);
        else st_next = ST_GAP;
      end
      default: st_next = ST_MODE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) rsp.valid <= 1'b0;
    else if (adv) rsp.valid <= v6;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.distance <= dist_next;
      rsp.status   <= st_next;
    end
  end

  // checks
  `PDM_ASSERT(a_ready_when_empty, clk, rst, !rsp.valid |-> req.ready, "ready low with empty output")
  `PDM_ASSERT(a_error_zero, clk, rst, (rsp.valid && rsp.status != ST_OK) |-> (rsp.distance == '0), "error result with nonzero distance")
  `PDM_ASSERT_NEXT(a_stall_holds, clk, rst, rsp.valid && !rsp.ready, $stable(sb_v), "root pipe moved during stall")

endmodule

`default_nettype wire

>>> rtl/core/pdm_root_step.sv
// ---------------------------------------------------------------------------
// pdm_root_step
// one bit of the rounding root: shift-add trial against the remainder
// ---------------------------------------------------------------------------
`default_nettype none

module pdm_root_step
  import pdm_pkg::*;
#(
  parameter int Bit = 24
) (
  input  logic  clk,
  input  logic  adv,
  input  root_t din,
  output root_t dout
);

  logic signed [RootW-1:0] delta;
  logic                    take;

  // growing m by 2^(Bit+1) raises m*m*den by this much
  always_comb begin
    delta = (RootW'(din.t) <<< (Bit + 2))
          + signed'(RootW'(din.den) << (2 * Bit + 2));
    take  = (delta <= din.r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout.den <= din.den;
      if (take) begin
        dout.r <= din.r - delta;
        dout.t <= din.t + signed'(TW'(din.den) << (Bit + 1));
        dout.n <= din.n | (DistW'(1) << Bit);
      end else begin
        dout.r <= din.r;
        dout.t <= din.t;
        dout.n <= din.n;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pdm_cos_step.sv
// ---------------------------------------------------------------------------
// pdm_cos_step
// one horner step t' = 1 - round(x2*t)/k, k picked by the cos or sin branch
// ---------------------------------------------------------------------------
`default_nettype none

module pdm_cos_step
  import pdm_pkg::*;
#(
  parameter int KC = 90,
  parameter int KS = 110
) (
  input  logic clk,
  input  cos_t din,
  output cos_t dout
);

  // exact floor division of values below 2^31 by reciprocal multiply
  localparam int LC = $clog2(KC);
  localparam int LS = $clog2(KS);
  localparam longint unsigned MC = ((64'd1 << (31 + LC)) + KC - 1) / KC;
  localparam longint unsigned MS = ((64'd1 << (31 + LS)) + KS - 1) / KS;
  localparam int PW = 2 * XW + 1;
  localparam int VW = 32;
  localparam int MW = 65;

  logic [PW-1:0] prod_a;
  cos_t          mid_a;
  logic [PW-1:0] rnd;
  logic [VW-1:0] v;
  logic [MW-1:0] prod_b;
  cos_t          mid_b;
  logic [QW-1:0] q;

  always_ff @(posedge clk) begin
    prod_a <= PW'(din.x2) * PW'(din.t);
    mid_a  <= din;
  end

  always_comb begin
    rnd = prod_a + PW'(Q30Half);
    v   = VW'(rnd[PW-1:30]) + (mid_a.use_sin ? VW'(KS / 2) : VW'(KC / 2));
  end

  always_ff @(posedge clk) begin
    prod_b <= MW'(v) * (mid_a.use_sin ? MW'(MS) : MW'(MC));
    mid_b  <= mid_a;
  end

  always_comb begin
    q = mid_b.use_sin ? QW'(prod_b >> (31 + LS)) : QW'(prod_b >> (31 + LC));
    dout   = mid_b;
    dout.t = Q30One - q;
  end

endmodule

`default_nettype wire

>>> rtl/core/pdm_cosine.sv
// ---------------------------------------------------------------------------
// pdm_cosine
// free-running cosine of an angle register: q30 magnitude and sign
// ---------------------------------------------------------------------------
`default_nettype none

module pdm_cosine
  import pdm_pkg::*;
(
  input  logic                   clk,
  input  logic signed [AngW-1:0] angle,
  output logic [QW-1:0]          mag,
  output logic                   neg
);

  localparam int WW = AngW + 3;

  logic signed [WW-1:0] w0, w1, w2;
  logic [RedW-1:0]      red1;
  logic [RedW-1:0]      f1, f2;
  logic                 ng, us;
  logic [FoldW-1:0]     ap;
  logic [FoldW-1:0]     ap2;
  logic                 ng2, us2;
  logic [XW-1:0]        xi3, xi4;
  logic [UW-1:0]        u3;
  logic                 ng3, us3, ng4, us4;
  logic [UpW-1:0]       up4;
  logic [XW-1:0]        x5;
  logic                 ng5, us5;
  logic [2*XW-1:0]      x2p6;
  logic [2*XW-1:0]      rnd6;
  logic [XW-1:0]        x6;
  logic                 ng6, us6;
  cos_t                 chain [HornerSteps+1];
  logic [2*XW:0]        fp;
  logic [2*XW:0]        frnd;
  cos_t                 fin;

  // reduce into one turn
  always_comb begin
    w0 = WW'(angle);
    w1 = (w0 < 0) ? w0 + WW'(2 * Turn) : w0;
    w2 = (w1 >= WW'(Turn)) ? w1 - WW'(Turn) : w1;
  end

  always_ff @(posedge clk) begin
    red1 <= w2[RedW-1:0];
  end

  // fold into the first octant, noting sign and whether sine is used
  always_comb begin
    f1 = (red1 > RedW'(Half)) ? RedW'(Turn) - red1 : red1;
    ng = (f1 > RedW'(Quarter));
    f2 = ng ? RedW'(Half) - f1 : f1;
    us = (f2 > RedW'(Eighth));
    ap = us ? FoldW'(RedW'(Quarter) - f2) : FoldW'(f2);
  end

  always_ff @(posedge clk) begin
    ap2 <= ap;
    ng2 <= ng;
    us2 <= us;
    xi3 <= XW'(ap2) * XW'(PiQuot);
    u3  <= UW'(ap2) * UW'(PiRem) + UW'(RadBias);
    ng3 <= ng2;
    us3 <= us2;
    up4 <= UpW'(u3) * UpW'(Recip18k);
    xi4 <= xi3;
    ng4 <= ng3;
    us4 <= us3;
    x5  <= xi4 + XW'(up4[UpW-1:Recip18kShift]);
    ng5 <= ng4;
    us5 <= us4;
    x2p6 <= (2 * XW)'(x5) * (2 * XW)'(x5);
    x6   <= x5;
    ng6  <= ng5;
    us6  <= us5;
  end

  always_comb begin
    rnd6 = x2p6 + (2 * XW)'(Q30Half);
  end

  always_ff @(posedge clk) begin
    chain[0].x       <= x6;
    chain[0].x2      <= rnd6[2*XW-1:30];
    chain[0].t       <= Q30One;
    chain[0].use_sin <= us6;
    chain[0].neg     <= ng6;
  end

  for (genvar g = 0; g < HornerSteps; g++) begin : g_horner
    pdm_cos_step #(
      .KC (HornerKCos[g]),
      .KS (HornerKSin[g])
    ) u_step (
      .clk  (clk),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  // sine branch needs the last multiply by x
  always_ff @(posedge clk) begin
    fp  <= (2 * XW + 1)'(chain[HornerSteps].x) * (2 * XW + 1)'(chain[HornerSteps].t);
    fin <= chain[HornerSteps];
  end

  always_comb begin
    frnd = fp + (2 * XW + 1)'(Q30Half);
  end

  always_ff @(posedge clk) begin
    mag <= fin.use_sin ? frnd[2*XW:30] : fin.t;
    neg <= fin.neg;
  end

endmodule

`default_nettype wire

>>> tb/planar_distance_measure_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// planar_distance_measure_test
// self-checking bench for the planar distance block: two tables of directed
// measurements, then random phases under several register settings, with
// random gaps and stalls on both channels, checked against a local predictor
// ---------------------------------------------------------------------------
module planar_distance_measure_test;
  import pdm_pkg::*;

  localparam int IdleLimit   = 3000;
  localparam int DrainCycles = 40;
  localparam int Phases      = 8;
  localparam int PhaseItems  = 228;
  localparam longint unsigned QOne  = 64'd1 << 30;
  localparam longint unsigned QHalf = 64'd1 << 29;
  localparam longint unsigned PiQ30 = 64'd3373259426;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  typedef struct {
    logic signed [OutW-1:0] distance;
    status_t                st;
  } measure_t;

  typedef struct {
    cmd_t                     cmd;
    logic signed [CoordW-1:0] pt [8];
    bit                       pinned;
    measure_t                 res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  pdm_in_if  req ();
  pdm_out_if rsp ();

  planar_distance_measure dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req), .rsp(rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // local copy of the registers
  bit                  pt_en, ln_en;
  logic [AngW-1:0]     pt_ang, ln_ang;
  logic [GapW-1:0]     gap_lim;

  measure_t expected_q [$];
  measure_t pin_res;
  bit       pin_use = 1'b0;
  int       errors = 0;
  int       idle_cycles = 0;
  int       status_seen [4];
  int       results_seen = 0;
  bit       stall_on = 1'b1;

  function automatic logic [DistW-1:0] rounded_root(logic [127:0] num, logic [63:0] den);
    logic [63:0]  n, c, k;
    logic [127:0] prod;
    n = 0;
    for (int b = 24; b >= 0; b--) begin
      c = n | (64'd1 << b);
      k = 2 * c - 1;
      prod = 128'(k * k) * 128'(den);
      if (prod <= num) n = c;
    end
    return n[DistW-1:0];
  endfunction

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b + QHalf) >> 30;
  endfunction

  function automatic longint unsigned qstep(longint unsigned x2, longint unsigned t,
                                            longint unsigned k);
    return QOne - (qmul(x2, t) + k / 2) / k;
  endfunction

  function automatic longint unsigned cos_q30(logic [AngW-1:0] ang, output bit neg);
    longint a;
    longint unsigned x, x2, t;
    a = longint'($signed(ang)) % 36000;
    if (a < 0) a += 36000;
    if (a > 18000) a = 36000 - a;
    neg = 1'b0;
    if (a > 9000) begin
      neg = 1'b1;
      a = 18000 - a;
    end
    if (a <= 4500) begin
      x = (longint'(a) * PiQ30 + 9000) / 18000;
      x2 = qmul(x, x);
      t = qstep(x2, QOne, 90);
      t = qstep(x2, t, 56);
      t = qstep(x2, t, 30);
      t = qstep(x2, t, 12);
      return qstep(x2, t, 2);
    end
    x = (longint'(9000 - a) * PiQ30 + 9000) / 18000;
    x2 = qmul(x, x);
    t = qstep(x2, QOne, 110);
    t = qstep(x2, t, 72);
    t = qstep(x2, t, 42);
    t = qstep(x2, t, 20);
    t = qstep(x2, t, 6);
    return qmul(x, t);
  endfunction

  function automatic logic signed [OutW-1:0] projected(logic [DistW-1:0] d,
                                                       logic [AngW-1:0] ang);
    bit neg;
    longint unsigned c, m;
    c = cos_q30(ang, neg);
    m = (longint'(d) * c + QHalf) >> 30;
    return neg ? -OutW'(m) : OutW'(m);
  endfunction

  // height of p above line a-b; zero return means the line has no length
  function automatic bit line_height(longint px, longint py, longint ax, longint ay,
                                     longint bx, longint by, output logic [DistW-1:0] h);
    longint ux, uy, wx, wy, cr, len2;
    logic [127:0] c;
    ux = bx - ax; uy = by - ay; wx = px - ax; wy = py - ay;
    cr = ux * wy - uy * wx;
    len2 = ux * ux + uy * uy;
    h = '0;
    if (len2 == 0) return 1'b0;
    c = 128'(cr < 0 ? -cr : cr) << 9;
    h = rounded_root(c * c, len2);
    return 1'b1;
  endfunction

  function automatic measure_t predict_measure(cmd_t cmd, logic signed [CoordW-1:0] pt [8]);
    measure_t r;
    longint dx, dy;
    logic [DistW-1:0] d, h0, h1, diff;
    r.distance = '0;
    r.st = ST_OK;
    case (cmd)
      CMD_POINT: begin
        dx = longint'(pt[0]) - longint'(pt[2]);
        dy = longint'(pt[1]) - longint'(pt[3]);
        d = rounded_root(128'(dx * dx + dy * dy) << 18, 1);
        r.distance = pt_en ? projected(d, pt_ang) : OutW'(d);
      end
      CMD_LINE: begin
        if (!line_height(pt[0], pt[1], pt[4], pt[5], pt[6], pt[7], h0)) r.st = ST_DEGEN;
        else r.distance = ln_en ? projected(h0, ln_ang) : OutW'(h0);
      end
      CMD_PAIR: begin
        if (!line_height(pt[0], pt[1], pt[4], pt[5], pt[6], pt[7], h0) ||
            !line_height(pt[2], pt[3], pt[4], pt[5], pt[6], pt[7], h1)) begin
          r.st = ST_DEGEN;
        end else begin
          diff = h0 > h1 ? h0 - h1 : h1 - h0;
          if (diff < gap_lim) r.distance = OutW'((27'(h0) + 27'(h1) + 1) >> 1);
          else r.st = ST_GAP;
        end
      end
      default: r.st = ST_MODE;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $time);
    errors++;
  endtask

  // request side: predict, or take the pinned result, on every accepted transaction
  always @(posedge clk) begin
    logic signed [CoordW-1:0] pt [8];
    if (!rst && req.valid && req.ready) begin
      pt = '{req.p0_x, req.p0_y, req.p1_x, req.p1_y, req.p2_x, req.p2_y, req.p3_x, req.p3_y};
      if (pin_use) expected_q.push_back(pin_res);
      else expected_q.push_back(predict_measure(cmd_t'(req.cmd), pt));
    end
  end

  // result side: compare with the oldest expectation
  always @(posedge clk) begin
    measure_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      results_seen++;
      status_seen[rsp.status]++;
      if (expected_q.size() == 0) begin
        $display("unexpected result at %0t", $time);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (rsp.distance !== e.distance) report_mismatch("distance", e.distance, rsp.distance);
        if (rsp.status !== e.st) report_mismatch("status", e.st, rsp.status);
      end
    end
  end

  // result stalls: mostly short, some long, none started while stall_on is clear
  always @(posedge clk) begin
    int stall_left;
    if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp.ready <= 1'b1;
      if (stall_on && $urandom_range(0, 3) == 0)
        stall_left = $urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 40);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("no transaction for %0d cycles", IdleLimit);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_PT_EN:  pt_en = val[0];
      REG_PT_ANG: pt_ang = val[AngW-1:0];
      REG_LN_EN:  ln_en = val[0];
      REG_LN_ANG: ln_ang = val[AngW-1:0];
      REG_GAP:    gap_lim = val[GapW-1:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic send_measure(row_t r, bit gaps);
    int gap;
    req.valid <= 1'b1;
    req.cmd <= r.cmd;
    {req.p0_x, req.p0_y, req.p1_x, req.p1_y} <= {r.pt[0], r.pt[1], r.pt[2], r.pt[3]};
    {req.p2_x, req.p2_y, req.p3_x, req.p3_y} <= {r.pt[4], r.pt[5], r.pt[6], r.pt[7]};
    pin_use <= r.pinned;
    pin_res <= r.res;
    do @(posedge clk); while (!req.ready);
    gap = !gaps ? 0 : ($urandom_range(0, 9) < 8 ? $urandom_range(0, 2) : $urandom_range(3, 30));
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CoordW'($urandom);
      4, 5, 6:    return CoordW'($signed($urandom_range(0, 127)) - 64);
      7:          return CoordW'($signed($urandom_range(0, 4095)) - 2048);
      8:          return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default:    return CoordW'($signed($urandom_range(0, 2)) - 1);
    endcase
  endfunction

  function automatic row_t rand_row();
    row_t r;
    int pick;
    pick = $urandom_range(0, 19);
    r.cmd = pick < 6 ? CMD_POINT : pick < 12 ? CMD_LINE : pick < 19 ? CMD_PAIR : CMD_BAD;
    foreach (r.pt[i]) r.pt[i] = rand_coord();
    // pair: keep p1 close to p0 so the gap test goes both ways
    if (r.cmd == CMD_PAIR && $urandom_range(0, 2) != 0) begin
      r.pt[2] = r.pt[0] + CoordW'($signed($urandom_range(0, 8)) - 4);
      r.pt[3] = r.pt[1] + CoordW'($signed($urandom_range(0, 8)) - 4);
    end
    if (r.cmd != CMD_POINT && $urandom_range(0, 24) == 0) begin
      r.pt[6] = r.pt[4];
      r.pt[7] = r.pt[5];
    end
    r.pinned = 1'b0;
    r.res = '{distance: '0, st: ST_OK};
    return r;
  endfunction

  function automatic row_t mk(cmd_t c, int p [8], bit pinned, int d, status_t s);
    row_t r;
    r.cmd = c;
    foreach (r.pt[i]) r.pt[i] = CoordW'(p[i]);
    r.pinned = pinned;
    r.res = '{distance: OutW'(d), st: s};
    return r;
  endfunction

  row_t directed [$];
  int   angle_picks [10] = '{0, 9000, 18000, 27000, 4500, 4501, -36000, 36000, -65536, 65535};

  initial begin
    req.valid = 1'b0;
    req.cmd = CMD_POINT;
    {req.p0_x, req.p0_y, req.p1_x, req.p1_y} = '0;
    {req.p2_x, req.p2_y, req.p3_x, req.p3_y} = '0;
    rsp.ready = 1'b0;
    {pt_en, ln_en, pt_ang, ln_ang, gap_lim} = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers still at reset: no projection, gap limit zero
    directed = '{
      mk(CMD_BAD,   '{0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, ST_MODE),
      mk(CMD_BAD,   '{-32768, 32767, -32768, 32767, 1, 2, 3, 4}, 1, 0, ST_MODE),
      mk(CMD_POINT, '{0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, ST_OK),
      mk(CMD_POINT, '{0, 0, 3, 4, 0, 0, 0, 0}, 1, 1280, ST_OK),
      mk(CMD_POINT, '{-32768, -32768, 32767, 32767, 0, 0, 0, 0}, 0, 0, ST_OK),
      mk(CMD_POINT, '{32767, -32768, -32768, 32767, 0, 0, 0, 0}, 0, 0, ST_OK),
      mk(CMD_POINT, '{1, 1, 2, 2, 0, 0, 0, 0}, 0, 0, ST_OK),
      mk(CMD_LINE,  '{0, 5, 0, 0, 0, 0, 10, 0}, 1, 1280, ST_OK),
      mk(CMD_LINE,  '{5, 5, 0, 0, 7, 7, 7, 7}, 1, 0, ST_DEGEN),
      mk(CMD_LINE,  '{32767, 32767, 0, 0, -32768, -32768, 32767, -32768}, 0, 0, ST_OK),
      mk(CMD_LINE,  '{-32768, 32767, 0, 0, -32768, -32768, 32767, 32767}, 0, 0, ST_OK),
      mk(CMD_LINE,  '{3, 1, 0, 0, 0, 0, 1, 1}, 0, 0, ST_OK),
      mk(CMD_PAIR,  '{0, 5, 9, 5, 0, 0, 10, 0}, 1, 0, ST_GAP),
      mk(CMD_PAIR,  '{0, 5, 9, 5, -3, 2, -3, 2}, 1, 0, ST_DEGEN),
      mk(CMD_PAIR,  '{32767, 32767, -32768, -32768, -32768, 0, 32767, 0}, 1, 0, ST_GAP)
    };
    foreach (directed[i]) send_measure(directed[i], 1'b0);
    req.valid <= 1'b0;
    pin_use <= 1'b0;
    drain();

    // projections at the angle extremes, gap limit fully open
    write_reg(REG_PT_EN, 1);
    write_reg(REG_PT_ANG, CfgDataW'(18000));
    write_reg(REG_LN_EN, 1);
    write_reg(REG_LN_ANG, CfgDataW'(-36000));
    write_reg(REG_GAP, '1);
    write_reg(RegUnused, '1);
    cfg_we <= 1'b0;
    @(posedge clk);
    directed = '{
      mk(CMD_POINT, '{0, 0, 3, 4, 0, 0, 0, 0}, 1, -1280, ST_OK),
      mk(CMD_LINE,  '{0, 5, 0, 0, 0, 0, 10, 0}, 1, 1280, ST_OK),
      mk(CMD_PAIR,  '{0, 5, 9, 5, 0, 0, 10, 0}, 1, 1280, ST_OK),
      mk(CMD_PAIR,  '{32767, 32767, -32768, -32768, -32768, 0, 32767, 0}, 0, 0, ST_OK),
      mk(CMD_POINT, '{-32768, -32768, 32767, 32767, 0, 0, 0, 0}, 0, 0, ST_OK)
    };
    foreach (directed[i]) send_measure(directed[i], 1'b1);
    req.valid <= 1'b0;
    pin_use <= 1'b0;

    for (int ph = 0; ph < Phases; ph++) begin
      drain();
      write_reg(REG_PT_EN, CfgDataW'(ph % 3 != 0));
      write_reg(REG_PT_ANG, ph < 4 ? CfgDataW'(angle_picks[ph * 2 + 2])
                                   : CfgDataW'($urandom_range(0, 131071)));
      write_reg(REG_LN_EN, CfgDataW'(ph % 2));
      write_reg(REG_LN_ANG, ph < 4 ? CfgDataW'(angle_picks[ph * 2 + 3])
                                   : CfgDataW'($urandom_range(0, 131071)));
      write_reg(REG_GAP, ph == 0 ? CfgDataW'(0) : ph == 1 ? {CfgDataW{1'b1}}
                                 : CfgDataW'($urandom_range(1, 4096)));
      cfg_we <= 1'b0;
      stall_on = ph != 2;
      @(posedge clk);
      for (int i = 0; i < PhaseItems; i++) send_measure(rand_row(), ph != 2);
      req.valid <= 1'b0;
    end
    stall_on = 1'b1;

    drain();
    if (expected_q.size() != 0) begin
      $display("%0d expected results never arrived", expected_q.size());
      errors++;
    end
    $display("checked %0d results over %0d register settings", results_seen, Phases + 2);
    $display("status counts: ok %0d, gap %0d, degenerate %0d, bad mode %0d, errors %0d",
             status_seen[ST_OK], status_seen[ST_GAP], status_seen[ST_DEGEN],
             status_seen[ST_MODE], errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
